// ----- sv/ccpd_pkg.sv -----
// shared types, constants and crc function for the cobs crc-8 packet deframer
`default_nettype none
package ccpd_pkg;

   // trailer layout: id, device, length, crc
   localparam int TRAILER_BYTES = 4;

   localparam logic [7:0] CRC_POLY   = 8'hB2;
   localparam logic [7:0] CRC_XOROUT = 8'hFF;
   localparam logic [7:0] DELIMITER  = 8'h00;
   localparam logic [7:0] CODE_MAX   = 8'hFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_LENGTH    = 2'd2,
      STATUS_CRC       = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    item_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      status_type  frame_status;
      logic [7:0]  device_field;
      logic [7:0]  id_field;
      logic [15:0] payload_length;
   } result_type;

   // reflected crc-8 update over one byte
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- sv/ccpd_in_reg.sv -----
// input register stage holding one received byte
`default_nettype none
module ccpd_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [7:0] req_in_byte,
   output logic            req_stall,
   input  wire logic       advance,
   output logic            item_valid,
   output logic [7:0]      item_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // hold while the held item cannot move on
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
      end
   end

endmodule
`default_nettype wire

// ----- sv/ccpd_decode.sv -----
// cobs decode, crc, trailer window and verdict logic with frame state
`default_nettype none
module ccpd_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire logic [7:0]           item_byte,
   input  wire logic                 out_free,
   output logic                      advance,
   output logic                      result_valid,
   output ccpd_pkg::result_type      result
);

   localparam int TB = ccpd_pkg::TRAILER_BYTES;

   logic [7:0]  group_ff, group_in;
   logic        zero_pending_ff, zero_pending_in;
   logic        nonempty_ff, nonempty_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  win_ff [TB];
   logic [7:0]  win_in [TB];

   logic        is_delim, is_code, push_en, enough, has_result;
   logic [7:0]  push_data;
   ccpd_pkg::status_type status;

   assign is_delim = (item_byte == ccpd_pkg::DELIMITER);
   assign is_code  = !is_delim && (group_ff == 8'd0);
   assign push_en  = !is_delim && (!is_code || zero_pending_ff);
   assign push_data = is_code ? 8'd0 : item_byte;
   assign enough   = (count_ff >= 16'(TB));

   // verdict status, in order of precedence
   always_comb begin
      if (group_ff != 8'd0) begin
         status = ccpd_pkg::STATUS_MALFORMED;
      end else if (!enough || win_ff[TB-2] != count_ff[7:0]) begin
         status = ccpd_pkg::STATUS_LENGTH;
      end else if ((crc_ff ^ ccpd_pkg::CRC_XOROUT) != win_ff[TB-1]) begin
         status = ccpd_pkg::STATUS_CRC;
      end else begin
         status = ccpd_pkg::STATUS_OK;
      end
   end

   // result selection
   always_comb begin
      result = '0;
      has_result = 1'b0;
      if (is_delim) begin
         has_result = nonempty_ff;
         result.item_kind = ccpd_pkg::KIND_VERDICT;
         result.frame_status = status;
         if (enough) begin
            result.device_field   = win_ff[TB-3];
            result.id_field       = win_ff[TB-4];
            result.payload_length = count_ff - 16'(TB);
         end
      end else if (push_en && enough) begin
         has_result = 1'b1;
         result.item_kind     = ccpd_pkg::KIND_PAYLOAD;
         result.payload_byte  = win_ff[0];
         result.payload_index = count_ff - 16'(TB);
      end
   end

   // an item moves on unless its result finds the output full
   assign advance      = item_valid && (out_free || !has_result);
   assign result_valid = advance && has_result;

   // next frame state
   always_comb begin
      group_in        = group_ff;
      zero_pending_in = zero_pending_ff;
      nonempty_in     = nonempty_ff;
      count_in        = count_ff;
      crc_in          = crc_ff;
      for (int k = 0; k < TB; k++) begin
         win_in[k] = win_ff[k];
      end
      if (is_delim) begin
         group_in        = 8'd0;
         zero_pending_in = 1'b0;
         nonempty_in     = 1'b0;
         count_in        = 16'd0;
         crc_in          = 8'd0;
         for (int k = 0; k < TB; k++) begin
            win_in[k] = 8'd0;
         end
      end else begin
         nonempty_in = 1'b1;
         if (is_code) begin
            zero_pending_in = (item_byte != ccpd_pkg::CODE_MAX);
            group_in        = item_byte - 8'd1;
         end else begin
            group_in = group_ff - 8'd1;
         end
         if (push_en) begin
            if (count_ff != 16'd0) begin
               crc_in = ccpd_pkg::crc_fold(crc_ff, win_ff[TB-1]);
            end
            for (int k = 0; k < TB - 1; k++) begin
               win_in[k] = win_ff[k+1];
            end
            win_in[TB-1] = push_data;
            if (count_ff != ccpd_pkg::COUNT_MAX) begin
               count_in = count_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff        <= 8'd0;
         zero_pending_ff <= 1'b0;
         nonempty_ff     <= 1'b0;
         count_ff        <= 16'd0;
         crc_ff          <= 8'd0;
         for (int k = 0; k < TB; k++) begin
            win_ff[k] <= 8'd0;
         end
      end else if (advance) begin
         group_ff        <= group_in;
         zero_pending_ff <= zero_pending_in;
         nonempty_ff     <= nonempty_in;
         count_ff        <= count_in;
         crc_ff          <= crc_in;
         for (int k = 0; k < TB; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

endmodule
`default_nettype wire

// ----- sv/ccpd_out_reg.sv -----
// result register stage toward the result channel
`default_nettype none
module ccpd_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire ccpd_pkg::result_type result,
   output logic                      out_free,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output ccpd_pkg::result_type      rsp_result
);

   logic                 valid_ff, valid_in;
   ccpd_pkg::result_type result_ff;

   // free when empty or being taken this cycle
   assign out_free   = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

endmodule
`default_nettype wire

// ----- sv/cobs_crc8_packet_deframer.sv -----
// Streaming COBS deframer with CRC-8 trailer check, one byte item per cycle
// while neither side stalls. A result item passes through the input register,
// then the result register.
// The frame state registers are updated from their own values on each accepted byte.
// Reset: synchronous; clears frame state and both stages' valid flags.
`default_nettype none
module cobs_crc8_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_payload_index,
   output logic [1:0]       rsp_frame_status,
   output logic [7:0]       rsp_device_field,
   output logic [7:0]       rsp_id_field,
   output logic [15:0]      rsp_payload_length
);

   logic                 advance, item_valid, out_free, result_valid;
   logic [7:0]           item_byte;
   ccpd_pkg::result_type result, rsp_result;

   // input stage
   ccpd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   // decode and frame state
   ccpd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item_byte    (item_byte),
      .out_free     (out_free),
      .advance      (advance),
      .result_valid (result_valid),
      .result       (result)
   );

   // result stage
   ccpd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_item_kind      = rsp_result.item_kind;
   assign rsp_payload_byte   = rsp_result.payload_byte;
   assign rsp_payload_index  = rsp_result.payload_index;
   assign rsp_frame_status   = rsp_result.frame_status;
   assign rsp_device_field   = rsp_result.device_field;
   assign rsp_id_field       = rsp_result.id_field;
   assign rsp_payload_length = rsp_result.payload_length;

endmodule
`default_nettype wire
